@@ rtl/nonoverlap_pattern_occurrence_counter_top_macros.svh @@
// assertion macros for the pattern occurrence counter
`ifndef NONOVERLAP_PATTERN_OCCURRENCE_COUNTER_TOP_MACROS_SVH
`define NONOVERLAP_PATTERN_OCCURRENCE_COUNTER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define NPOC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define NPOC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/npoc_pkg.sv @@
// types, constants and helpers shared by the pattern occurrence counter
package npoc_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int SYM_W = 8;
	localparam int OUT_COUNT_W = 16;
	localparam int LEN_REG_W = 5;
	localparam int CHAR_REG_W = 64;
	localparam int CHARS_W = 2 * CHAR_REG_W;
	localparam int REG_CHARS = CHARS_W / SYM_W;
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = $clog2(MAX_PATTERN);
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;
	localparam int MIN_LEN = 2;
	localparam int RESET_LEN = 2;

	typedef enum logic [1:0] {
		REG_LENGTH    = 2'd0,
		REG_CHARS_LOW = 2'd1,
		REG_CHARS_HIGH = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last_symbol;
	} sym_item_t;

	typedef struct packed {
		logic [OUT_COUNT_W-1:0] occurrence_count;
		logic                   occurrence_hit;
		logic                   sequence_done;
	} res_item_t;

	typedef struct packed {
		logic [LEN_W-1:0]   len_used;
		logic [CHARS_W-1:0] chars;
	} cfg_t;

	typedef struct packed {
		logic             en;
		logic             clear;
		logic [SYM_W-1:0] symbol;
	} cell_ctl_t;

	function automatic logic [OUT_COUNT_W-1:0] clip_count(input logic [COUNT_WIDTH-1:0] v);
		logic [OUT_COUNT_W-1:0] r;
		if (COUNT_WIDTH > OUT_COUNT_W) begin
			r = (v > COUNT_WIDTH'({OUT_COUNT_W{1'b1}})) ? {OUT_COUNT_W{1'b1}}
				: OUT_COUNT_W'(v);
		end else begin
			r = OUT_COUNT_W'(v);
		end
		return r;
	endfunction

endpackage

@@ rtl/nonoverlap_pattern_occurrence_counter_top.sv @@
// top level: config port, row of position cells, occurrence counter, result register
//
// channel | direction | payload            | handshake
// sym     | in        | sym_item_t         | sym_valid / sym_stall
// res     | out       | res_item_t         | res_valid / res_stall
// apb     | in/out    | 64-bit registers   | psel / penable, pready always high
//
// one symbol per cycle while sym_stall is low: every cell compares and the priority
// link runs through the row in the accepting cycle; the result is registered.
// no clearing pass after reset, all counters clear at once.
// a stalled result holds the input off only while the result register is full.
`include "nonoverlap_pattern_occurrence_counter_top_macros.svh"
module nonoverlap_pattern_occurrence_counter_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sym_valid,
	output logic                         sym_stall,
	input  npoc_pkg::sym_item_t          sym_data,
	output logic                         res_valid,
	input  logic                         res_stall,
	output npoc_pkg::res_item_t          res_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [npoc_pkg::ADDR_W-1:0]  paddr,
	input  logic [npoc_pkg::DATA_W-1:0]  pwdata,
	output logic [npoc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	npoc_pkg::cfg_t                   cfg;
	npoc_pkg::cell_ctl_t              ctl;
	logic                             accept;
	logic [npoc_pkg::COUNT_WIDTH-1:0] cnt_arr [npoc_pkg::MAX_PATTERN];
	logic [npoc_pkg::MAX_PATTERN-1:0] found;
	logic [npoc_pkg::MAX_PATTERN-1:0] take;
	logic [npoc_pkg::IDX_W-1:0]       last_pos;
	logic                             hit;
	logic [npoc_pkg::COUNT_WIDTH-1:0] run_q;
	logic [npoc_pkg::COUNT_WIDTH-1:0] run_next;
	logic                             res_valid_q;
	npoc_pkg::res_item_t              res_q;

	npoc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign sym_stall = res_valid_q & res_stall;
	assign accept = sym_valid & ~sym_stall;

	assign ctl.en = accept;
	assign ctl.clear = sym_data.last_symbol;
	assign ctl.symbol = sym_data.symbol;

	for (genvar g = 0; g < npoc_pkg::MAX_PATTERN; g++) begin : g_cell
		logic [npoc_pkg::SYM_W-1:0]       ch;
		logic [npoc_pkg::COUNT_WIDTH-1:0] prev;
		logic                             fin;

		if (g < npoc_pkg::REG_CHARS) begin : g_ch
			assign ch = cfg.chars[g*npoc_pkg::SYM_W +: npoc_pkg::SYM_W];
		end else begin : g_zero
			assign ch = '0;
		end

		if (g == 0) begin : g_head
			assign prev = '0;
		end else begin : g_link
			assign prev = cnt_arr[g-1];
		end

		if (g == npoc_pkg::MAX_PATTERN - 1) begin : g_top
			assign fin = 1'b0;
		end else begin : g_down
			assign fin = found[g+1];
		end

		npoc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.ch        (ch),
			.active    (npoc_pkg::LEN_W'(g) < cfg.len_used),
			.is_first  (g == 0),
			.prev_cnt  (prev),
			.found_in  (fin),
			.cnt       (cnt_arr[g]),
			.found_out (found[g]),
			.take      (take[g])
		);
	end

	assign last_pos = npoc_pkg::IDX_W'(cfg.len_used - 1'b1);
	assign hit = take[last_pos];
	assign run_next = (hit && run_q != {npoc_pkg::COUNT_WIDTH{1'b1}}) ? run_q + 1'b1 : run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				run_q <= sym_data.last_symbol ? '0 : run_next;
			end
			res_valid_q <= accept | (res_valid_q & res_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.occurrence_count <= npoc_pkg::clip_count(run_next);
			res_q.occurrence_hit <= hit;
			res_q.sequence_done <= sym_data.last_symbol;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data = res_q;

	`NPOC_ASSERT_NOW(a_one_take, 1'b1, $onehot0(take), "more than one cell took the symbol")
	`NPOC_ASSERT_NOW(a_hit_count, res_valid_q && res_q.occurrence_hit,
		res_q.occurrence_count != '0, "hit reported with zero count")
	`NPOC_ASSERT_NEXT(a_seq_clear, accept && sym_data.last_symbol,
		run_q == '0 && cnt_arr[0] == '0, "state not cleared after sequence end")
	`NPOC_ASSERT_NEXT(a_hit_counts, accept && hit && !sym_data.last_symbol,
		run_q != '0, "occurrence not counted")

endmodule

@@ rtl/npoc_cfg.sv @@
// configuration registers behind the apb-style port
module npoc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [npoc_pkg::ADDR_W-1:0]  paddr,
	input  logic [npoc_pkg::DATA_W-1:0]  pwdata,
	output logic [npoc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output npoc_pkg::cfg_t               cfg
);

	logic [npoc_pkg::LEN_REG_W-1:0]  len_q;
	logic [npoc_pkg::CHAR_REG_W-1:0] chars_lo_q;
	logic [npoc_pkg::CHAR_REG_W-1:0] chars_hi_q;
	logic                            wr_en;
	npoc_pkg::reg_idx_t              idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign idx = npoc_pkg::reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= npoc_pkg::LEN_REG_W'(npoc_pkg::RESET_LEN);
			chars_lo_q <= '0;
			chars_hi_q <= '0;
		end else if (wr_en) begin
			case (idx)
				npoc_pkg::REG_LENGTH: len_q <= pwdata[npoc_pkg::LEN_REG_W-1:0];
				npoc_pkg::REG_CHARS_LOW: chars_lo_q <= pwdata[npoc_pkg::CHAR_REG_W-1:0];
				npoc_pkg::REG_CHARS_HIGH: chars_hi_q <= pwdata[npoc_pkg::CHAR_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			npoc_pkg::REG_LENGTH: prdata = npoc_pkg::DATA_W'(len_q);
			npoc_pkg::REG_CHARS_LOW: prdata = npoc_pkg::DATA_W'(chars_lo_q);
			npoc_pkg::REG_CHARS_HIGH: prdata = npoc_pkg::DATA_W'(chars_hi_q);
			default: prdata = '0;
		endcase
	end

	// clamp the length into the supported range
	always_comb begin
		if (32'(len_q) < 32'(npoc_pkg::MIN_LEN)) begin
			cfg.len_used = npoc_pkg::LEN_W'(npoc_pkg::MIN_LEN);
		end else if (32'(len_q) > 32'(npoc_pkg::MAX_PATTERN)) begin
			cfg.len_used = npoc_pkg::LEN_W'(npoc_pkg::MAX_PATTERN);
		end else begin
			cfg.len_used = npoc_pkg::LEN_W'(len_q);
		end
		cfg.chars = {chars_hi_q, chars_lo_q};
	end

endmodule

@@ rtl/npoc_cell.sv @@
// one pattern position: counter, compare and priority link
module npoc_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  npoc_pkg::cell_ctl_t               ctl,
	input  logic [npoc_pkg::SYM_W-1:0]        ch,
	input  logic                              active,
	input  logic                              is_first,
	input  logic [npoc_pkg::COUNT_WIDTH-1:0]  prev_cnt,
	input  logic                              found_in,
	output logic [npoc_pkg::COUNT_WIDTH-1:0]  cnt,
	output logic                              found_out,
	output logic                              take
);

	logic [npoc_pkg::COUNT_WIDTH-1:0] cnt_q;
	logic                             qual;

	assign qual = active & (ctl.symbol == ch) & (is_first | (cnt_q < prev_cnt));
	assign take = qual & ~found_in;
	assign found_out = found_in | qual;
	assign cnt = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.en) begin
			if (ctl.clear) begin
				cnt_q <= '0;
			end else if (take && cnt_q != {npoc_pkg::COUNT_WIDTH{1'b1}}) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule
